/* design/swipe_velocity_tracker_defines.svh */
// Assertion macros for the swipe velocity tracker.
`ifndef SWIPE_VELOCITY_TRACKER_DEFINES_SVH
`define SWIPE_VELOCITY_TRACKER_DEFINES_SVH
// Concurrent check that an implication holds at every clock edge outside reset.
`define SVT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Concurrent check that a signal keeps its value in the cycle after a condition.
`define SVT_ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);
`endif

/* design/svt_pkg.sv */
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types and constants of the swipe velocity tracker.
// ----------------------------------------------------------------------------
package svt_pkg;
    localparam int DEFAULT_DEPTH = 32;
    localparam logic [19:0] WINDOW_RESET = 20'd150000;
    localparam logic [23:0] GAIN_RESET = 24'd21845;
    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_GAIN = 1'b1;
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_APPEND, ST_TRIM_RD, ST_TRIM_CMP, ST_SUM_RD, ST_SUM_ACC,
        ST_DIV, ST_MUL, ST_PROJ, ST_OUT
    } svt_state_t;

    typedef struct packed {
        logic load;      // capture input item
        logic clear;     // clear history
        logic check;     // evaluate ordering
        logic append;    // write sample
        logic trim_rd;   // read entry for trim
        logic trim_cmp;  // compare trim entry
        logic sum_rd;    // read entry for sum
        logic sum_acc;   // accumulate
        logic div_start;
        logic div_step;
        logic mul;
        logic proj;
        logic out_load;
    } svt_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic order_ok;
        logic trim_more;
        logic sum_more;
        logic div_zero;
        logic div_done;
        logic out_busy;
    } svt_status_t;
endpackage

/* design/svt_ctrl.sv */
// ----------------------------------------------------------------------------
// svt_ctrl
// Sequencer that walks one item through check, append and trim (stored samples only),
// sum, divide, multiply, projection and output steps.
// ----------------------------------------------------------------------------
module svt_ctrl
    import svt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  svt_status_t sts,
    output logic        idle,
    output svt_cmd_t    cmd
);
    svt_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_fire) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (sts.is_clear) state_next = ST_SUM_RD;
                else if (sts.order_ok) state_next = ST_APPEND;
                else state_next = ST_SUM_RD;
            end
            ST_APPEND:   state_next = ST_TRIM_RD;
            ST_TRIM_RD:  state_next = ST_TRIM_CMP;
            ST_TRIM_CMP: state_next = sts.trim_more ? ST_TRIM_RD : ST_SUM_RD;
            ST_SUM_RD:   state_next = sts.sum_more ? ST_SUM_ACC : ST_DIV;
            ST_SUM_ACC:  state_next = ST_SUM_RD;
            ST_DIV:      if (sts.div_zero || sts.div_done) state_next = ST_MUL;
            ST_MUL:      state_next = ST_PROJ;
            ST_PROJ:     state_next = ST_OUT;
            ST_OUT:      if (!sts.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        idle = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:     cmd.load = in_fire;
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                cmd.clear = sts.is_clear;
            end
            ST_APPEND:   cmd.append = 1'b1;
            ST_TRIM_RD:  cmd.trim_rd = 1'b1;
            ST_TRIM_CMP: cmd.trim_cmp = 1'b1;
            ST_SUM_RD:
            begin
                cmd.sum_rd = 1'b1;
                cmd.div_start = !sts.sum_more;
            end
            ST_SUM_ACC:  cmd.sum_acc = 1'b1;
            ST_DIV:      cmd.div_step = !(sts.div_zero || sts.div_done);
            ST_MUL:      cmd.mul = 1'b1;
            ST_PROJ:     cmd.proj = 1'b1;
            ST_OUT:      cmd.out_load = !sts.out_busy;
            default:     cmd = '0;
        endcase
    end
endmodule

/* design/svt_datapath.sv */
// ----------------------------------------------------------------------------
// svt_datapath
// History ring buffer, running position, serial divider and projection.
// ----------------------------------------------------------------------------
module svt_datapath
    import svt_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEFAULT_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  svt_cmd_t           cmd,
    input  logic               in_op,
    input  logic signed [23:0] in_delta,
    input  logic [31:0]        in_ts,
    input  logic [19:0]        window,
    input  logic [23:0]        gain,
    input  logic               out_ready,
    output svt_status_t        sts,
    output logic               out_valid,
    output logic               res_accepted,
    output logic signed [31:0] res_position,
    output logic signed [31:0] res_velocity,
    output logic signed [31:0] res_projected
);
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = 24 + CW;
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

    // History memory (ring buffer).
    logic signed [23:0] mem_delta [HISTORY_DEPTH];
    logic [31:0]        mem_time  [HISTORY_DEPTH];
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [31:0]        newest_reg, newest_next;
    logic [31:0]        oldest_reg;
    logic signed [31:0] pos_reg, pos_next;
    logic               op_reg, acc_reg;
    logic signed [23:0] delta_reg;
    logic [31:0]        ts_reg;
    logic [CW-1:0]      walk_reg;
    logic [AW-1:0]      raddr;
    logic signed [23:0] rd_delta_reg;
    logic [31:0]        rd_time_reg;
    logic signed [SW-1:0] sum_reg;
    logic [AW-1:0]      waddr;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, a} + {1'b0, b};
        if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
        return s[AW-1:0];
    endfunction

    assign waddr = wrap_add(head_reg, (count_reg == DEPTH_C) ? '0 : count_reg);
    assign raddr = wrap_add(head_reg, walk_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem_delta[waddr] <= delta_reg;
            mem_time[waddr]  <= ts_reg;
        end
        if (cmd.trim_rd || cmd.sum_rd)
        begin
            rd_delta_reg <= mem_delta[raddr];
            rd_time_reg  <= mem_time[raddr];
        end
    end

    // Input capture and ordering status.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_op;
            delta_reg <= in_delta;
            ts_reg <= in_ts;
        end
    end

    assign sts.is_clear = (op_reg == OP_CLEAR);
    assign sts.order_ok = (count_reg == '0) || (ts_reg >= newest_reg);

    // Position update.
    logic signed [32:0] pos_sum;
    assign pos_sum = 33'(pos_reg) + 33'(delta_reg);

    // Trim compare: entry older than newest by more than the window.
    logic trim_old;
    assign trim_old = {1'b0, newest_reg} > ({1'b0, rd_time_reg} + 33'(window));
    assign sts.trim_more = trim_old && (count_reg > CW'(1));
    assign sts.sum_more = walk_reg < count_reg;

    always_comb
    begin
        head_next = head_reg;
        count_next = count_reg;
        newest_next = newest_reg;
        pos_next = pos_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            pos_next = '0;
        end
        if (cmd.append)
        begin
            if (count_reg == DEPTH_C)
                head_next = wrap_add(head_reg, CW'(1));
            else
                count_next = count_reg + CW'(1);
            newest_next = ts_reg;
            if (pos_sum > 33'sd2147483647) pos_next = 32'sh7fffffff;
            else if (pos_sum < -33'sd2147483648) pos_next = 32'sh80000000;
            else pos_next = pos_sum[31:0];
        end
        if (cmd.trim_cmp && sts.trim_more)
        begin
            head_next = wrap_add(head_reg, CW'(1));
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
            pos_reg <= '0;
            newest_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            count_reg <= count_next;
            pos_reg <= pos_next;
            newest_reg <= newest_next;
        end
    end

    // Walk pointer and accumulator.
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            acc_reg <= !sts.is_clear && sts.order_ok;
            walk_reg <= '0;
            sum_reg <= '0;
        end
        if (cmd.append || cmd.trim_cmp)
            walk_reg <= '0;
        if (cmd.sum_rd && sts.sum_more)
            walk_reg <= walk_reg + CW'(1);
        if (cmd.sum_acc)
        begin
            sum_reg <= sum_reg + SW'(rd_delta_reg);
            if (walk_reg == CW'(1))
                oldest_reg <= rd_time_reg;
        end
    end

    // Serial divider: |sum| * 1e6 / elapsed, restoring, one bit a cycle.
    localparam int NW = SW + 20;
    logic [NW-1:0]  num_reg;
    logic [32:0]    rem_reg;
    logic [31:0]    den_reg;
    logic           neg_reg, zero_reg;
    logic [6:0]     bit_reg;
    logic [NW-1:0]  mag;
    logic [32:0]    trial;
    logic signed [SW-1:0] sum_abs;

    assign sum_abs = sum_reg[SW-1] ? -sum_reg : sum_reg;
    assign mag = NW'(sum_abs[SW-2:0]) * NW'(1000000);
    assign trial = {rem_reg[31:0], num_reg[NW-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= mag;
            rem_reg <= '0;
            den_reg <= newest_reg - oldest_reg;
            neg_reg <= sum_reg[SW-1];
            zero_reg <= (count_reg < CW'(2)) || (newest_reg <= oldest_reg);
            bit_reg <= 7'(NW);
        end
        else if (cmd.div_step && !zero_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                num_reg <= {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                num_reg <= {num_reg[NW-2:0], 1'b0};
            end
            bit_reg <= bit_reg - 7'd1;
        end
    end

    assign sts.div_zero = zero_reg;
    assign sts.div_done = (bit_reg == 7'd0);

    // Velocity saturation, gain multiply, projection.
    logic signed [31:0] vel_reg;
    logic signed [56:0] prod;
    logic signed [56:0] travel;
    logic signed [57:0] proj_sum;
    logic signed [31:0] proj_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            if (zero_reg)
                vel_reg <= '0;
            else if (!neg_reg)
                vel_reg <= (num_reg > NW'(32'h7fffffff)) ? 32'sh7fffffff : num_reg[31:0];
            else
                vel_reg <= (num_reg > NW'(32'h80000000)) ? 32'sh80000000 : -num_reg[31:0];
        end
        if (cmd.proj)
            proj_reg <= (proj_sum > 58'sd2147483647) ? 32'sh7fffffff :
                        (proj_sum < -58'sd2147483648) ? 32'sh80000000 : proj_sum[31:0];
    end

    assign prod = 57'(vel_reg) * $signed({33'd0, gain});
    assign travel = prod[56] ? -((-prod) >>> 16) : (prod >>> 16);
    assign proj_sum = 58'(pos_reg) + 58'(travel);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_accepted <= acc_reg;
            res_position <= pos_reg;
            res_velocity <= vel_reg;
            res_projected <= proj_reg;
        end
    end

    assign sts.out_busy = out_valid && !out_ready;
endmodule

/* design/swipe_velocity_tracker.sv */
// The time from input transfer to result is set by the serial divider and the history walk;
// an item with nothing to divide skips the divider steps.
// Throughput: one item at a time; the next is taken once the controller is back in idle.
// A result held by the sink stalls the controller until the output register is free.
// Reset: asynchronous active low; history count, position and config registers take defaults.
// ----------------------------------------------------------------------------
// swipe_velocity_tracker
// Top level: stream ports, configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
`include "swipe_velocity_tracker_defines.svh"
module swipe_velocity_tracker
    import svt_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEFAULT_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // delta[23:0], timestamp_us[55:24]
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // position_now, velocity, projected_position
    output logic         m_tuser,   // accepted
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [23:0]  cfg_data
);
    logic [19:0] window_reg;
    logic [23:0] gain_reg;
    logic idle;
    svt_cmd_t cmd;
    svt_status_t sts;
    logic signed [31:0] pos, vel, proj;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_WINDOW) window_reg <= cfg_data[19:0];
            else gain_reg <= cfg_data;
        end
    end

    assign s_tready = idle;

    svt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && s_tready),
        .sts(sts), .idle(idle), .cmd(cmd)
    );

    svt_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_op(s_tuser),
        .in_delta(s_tdata[23:0]), .in_ts(s_tdata[55:24]),
        .window(window_reg), .gain(gain_reg), .out_ready(m_tready), .sts(sts),
        .out_valid(m_tvalid), .res_accepted(m_tuser), .res_position(pos),
        .res_velocity(vel), .res_projected(proj)
    );

    assign m_tdata = {proj, vel, pos};

    // Checks.
    `SVT_ASSERT(a_no_accept_busy, clk, rst_n, (!idle |-> !s_tready), "input taken while busy")
    `SVT_ASSERT_STABLE(a_out_hold, clk, rst_n, (m_tvalid && !m_tready), m_tdata, "result changed")
    `SVT_ASSERT(a_idle_no_load, clk, rst_n, (cmd.out_load |-> !idle), "result without item")
endmodule

/* dv/swipe_velocity_tracker_tb.sv */
// ----------------------------------------------------------------------------
// swipe_velocity_tracker_tb
// Self-checking bench: drives motion samples and clears with random gaps and
// stalls, predicts every result with a behavioral model of the tracker and
// compares each output transfer field by field.
// ----------------------------------------------------------------------------
module swipe_velocity_tracker_tb;
    import svt_pkg::*;

    localparam int DEPTH = 32;

    typedef struct packed {
        logic        op;
        logic [23:0] delta;
        logic [31:0] ts;
    } motion_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] projected;
    } track_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [23:0]  cfg_data;

    motion_t pending_motion[$];
    track_t  expected_tracks[$];
    int      fail_count;
    bit      pause_req;

    // Predictor state.
    logic [19:0]        pred_window;
    logic [23:0]        pred_gain;
    logic signed [31:0] hist_delta[DEPTH];
    logic [31:0]        hist_time[DEPTH];
    int                 hist_count;
    logic signed [31:0] pred_position;

    swipe_velocity_tracker u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Remove n entries from the oldest end of the history.
    function automatic void shift_out(input int n);
        for (int i = 0; i < hist_count - n; i++)
        begin
            hist_delta[i] = hist_delta[i + n];
            hist_time[i]  = hist_time[i + n];
        end
        hist_count -= n;
    endfunction

    // Work out the result of one input item and update the predicted state.
    function automatic track_t predict_track(input motion_t m);
        track_t  r;
        int      first;
        longint  total;
        longint  elapsed;
        longint  travel;
        logic signed [31:0] vel;
        r.accepted = 1'b0;
        if (m.op == OP_CLEAR)
        begin
            hist_count = 0;
            pred_position = 0;
        end
        else if (!(hist_count > 0 && m.ts < hist_time[hist_count - 1]))
        begin
            if (hist_count >= DEPTH)
                shift_out(1);
            hist_delta[hist_count] = $signed(m.delta);
            hist_time[hist_count]  = m.ts;
            hist_count++;
            pred_position = clamp32(longint'(pred_position) + longint'($signed(m.delta)));
            first = 0;
            while (first < hist_count && {32'd0, hist_time[hist_count - 1]} >
                   {32'd0, hist_time[first]} + {44'd0, pred_window})
                first++;
            if (first > 0)
                shift_out(first);
            r.accepted = 1'b1;
        end
        vel = 0;
        if (hist_count >= 2 && hist_time[hist_count - 1] > hist_time[0])
        begin
            total = 0;
            for (int i = 0; i < hist_count; i++)
                total += hist_delta[i];
            elapsed = longint'({32'd0, hist_time[hist_count - 1]}) -
                      longint'({32'd0, hist_time[0]});
            vel = clamp32((total * 1000000) / elapsed);
        end
        travel = (longint'(vel) * longint'({40'd0, pred_gain})) / 65536;
        r.position  = pred_position;
        r.velocity  = vel;
        r.projected = clamp32(longint'(pred_position) + travel);
        return r;
    endfunction

    // Driver: presents queued samples with random gaps between transfers.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap <= 0;
        end
        else if (s_tvalid && !s_tready)
        begin
            // Hold the item until it is taken.
        end
        else if (send_gap > 0)
        begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_motion.size() > 0 && !(pause_req && expected_tracks.size() > 0))
        begin
            motion_t m;
            m = pending_motion.pop_front();
            expected_tracks.push_back(predict_track(m));
            s_tvalid <= 1'b1;
            s_tdata  <= {m.ts, m.delta};
            s_tuser  <= m.op;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end
        else
            s_tvalid <= 1'b0;
    end

    // Monitor: random stalls on the result side and field comparison.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                track_t got;
                track_t want;
                got = {m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
                if (expected_tracks.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_tracks.pop_front();
                    if (got.accepted !== want.accepted)
                        $display("%0t: accepted exp %0d got %0d", $time, want.accepted,
                                 got.accepted);
                    if (got.position !== want.position)
                        $display("%0t: position exp %0d got %0d", $time,
                                 $signed(want.position), $signed(got.position));
                    if (got.velocity !== want.velocity)
                        $display("%0t: velocity exp %0d got %0d", $time,
                                 $signed(want.velocity), $signed(got.velocity));
                    if (got.projected !== want.projected)
                        $display("%0t: projected exp %0d got %0d", $time,
                                 $signed(want.projected), $signed(got.projected));
                    if (got !== want)
                        fail_count++;
                end
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Register write; callers issue it only while the block is idle.
    task automatic write_reg(input logic idx, input logic [23:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WINDOW)
            pred_window = value[19:0];
        else
            pred_gain = value;
    endtask

    task automatic wait_drained();
        while (pending_motion.size() > 0 || expected_tracks.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic void queue_motion(input logic op, input logic [23:0] d,
                                         input logic [31:0] t);
        motion_t m;
        m.op = op;
        m.delta = d;
        m.ts = t;
        pending_motion.push_back(m);
    endfunction

    // Random well-formed swipes with occasional clears and stale samples.
    task automatic random_phase(input int n);
        logic [31:0] now;
        int          pick;
        now = $urandom_range(0, 1000);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                queue_motion(OP_CLEAR, 24'($urandom), $urandom);
            else if (pick < 10)
                queue_motion(OP_PUSH, 24'($urandom), now - $urandom_range(1, 5000));
            else if (pick < 14)
                queue_motion(OP_PUSH, 24'($urandom), $urandom);
            else
            begin
                if ($urandom_range(0, 9) != 0)
                    now = now + $urandom_range(0, 20000);
                queue_motion(OP_PUSH, ($urandom_range(0, 4) == 0) ? 24'($urandom) :
                             24'($signed($urandom_range(0, 8000)) - 4000), now);
            end
            if (pick == 50)
                now = $urandom;
        end
        wait_drained();
    endtask

    initial
    begin
        fail_count    = 0;
        pause_req     = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_WINDOW;
        cfg_data      = '0;
        m_tready      = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        pred_window   = WINDOW_RESET;
        pred_gain     = GAIN_RESET;
        hist_count    = 0;
        pred_position = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, clear, equal and stale timestamps, overflow.
        queue_motion(OP_PUSH, 24'h7fffff, 32'd0);
        queue_motion(OP_PUSH, 24'h7fffff, 32'd0);
        queue_motion(OP_PUSH, 24'h7fffff, 32'd1);
        queue_motion(OP_PUSH, 24'h800000, 32'd2);
        queue_motion(OP_PUSH, 24'h000001, 32'd1);
        queue_motion(OP_PUSH, 24'h7fffff, 32'd149000);
        queue_motion(OP_PUSH, 24'h7fffff, 32'd400000);
        queue_motion(OP_CLEAR, 24'hffffff, 32'hffffffff);
        queue_motion(OP_PUSH, 24'h800000, 32'hfffffff0);
        queue_motion(OP_PUSH, 24'h800000, 32'hffffffff);
        queue_motion(OP_PUSH, 24'h000000, 32'hffffffff);
        queue_motion(OP_CLEAR, 24'h000000, 32'd0);
        for (int i = 0; i < 12; i++)
            queue_motion(OP_PUSH, 24'h7fffff, 32'd10 * i);
        wait_drained();

        // Fill the history past its depth so the oldest entries are evicted.
        write_reg(CFG_WINDOW, 24'd1000000);
        write_reg(CFG_GAIN, 24'hffffff);
        for (int i = 0; i < 300; i++)
            queue_motion(OP_PUSH, 24'h7fffff, 32'd1000 + i);
        wait_drained();

        // Zero-ish window, zero gain, and the reset values again.
        pause_req = 1'b1;
        write_reg(CFG_WINDOW, 24'd1);
        write_reg(CFG_GAIN, 24'd0);
        random_phase(100);
        pause_req = 1'b0;
        write_reg(CFG_WINDOW, 24'd0);
        random_phase(50);
        write_reg(CFG_WINDOW, {4'd0, WINDOW_RESET});
        write_reg(CFG_GAIN, GAIN_RESET);
        random_phase(400);
        write_reg(CFG_WINDOW, 24'd1000000);
        write_reg(CFG_GAIN, 24'hffffff);
        random_phase(300);
        write_reg(CFG_WINDOW, 24'($urandom_range(1, 1000000)));
        write_reg(CFG_GAIN, 24'($urandom));
        random_phase(300);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
